/* sv/aik_pkg.sv */
// aik_pkg: constants and the CORDIC arctangent table for arm_inverse_kinematics.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package aik_pkg;

    localparam int TAB_LEN  = 24;
    localparam int ACC_W    = 30;
    localparam int CW       = 50;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REACH  = 2'd1;
    localparam logic [1:0] ST_DEGEN  = 2'd2;

    localparam logic signed [ACC_W-1:0] ANG_90  = 30'sd94371840;
    localparam logic signed [ACC_W-1:0] ANG_180 = 30'sd188743680;

    function automatic logic [ACC_W-1:0] atan_tab(input logic [4:0] i);
        logic [ACC_W-1:0] v;
        begin
            case (i)
                5'd0:  v = 30'd47185920;
                5'd1:  v = 30'd27855475;
                5'd2:  v = 30'd14718068;
                5'd3:  v = 30'd7471121;
                5'd4:  v = 30'd3750058;
                5'd5:  v = 30'd1876857;
                5'd6:  v = 30'd938658;
                5'd7:  v = 30'd469357;
                5'd8:  v = 30'd234682;
                5'd9:  v = 30'd117342;
                5'd10: v = 30'd58671;
                5'd11: v = 30'd29335;
                5'd12: v = 30'd14668;
                5'd13: v = 30'd7334;
                5'd14: v = 30'd3667;
                5'd15: v = 30'd1833;
                5'd16: v = 30'd917;
                5'd17: v = 30'd458;
                5'd18: v = 30'd229;
                5'd19: v = 30'd115;
                5'd20: v = 30'd57;
                5'd21: v = 30'd29;
                5'd22: v = 30'd14;
                5'd23: v = 30'd7;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

/* sv/aik_isqrt.sv */
// aik_isqrt: pipelined integer square root, two result bits per stage.
// Depends on nothing; carries a side payload alongside the root.
`timescale 1ns / 1ps
`default_nettype none
module aik_isqrt #(
    parameter int IN_W = 44,
    parameter int SIDE_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic [IN_W-1:0]   in_val,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic [IN_W/2-1:0]      root,
    output logic [IN_W-1:0]        rem,
    output logic [SIDE_W-1:0]      out_side
);
    localparam int RW = IN_W / 2;
    localparam int NST = (RW + 1) / 2;

    logic [IN_W-1:0]   v_reg    [0:NST];
    logic [IN_W-1:0]   q_reg    [0:NST];
    logic [IN_W+1:0]   r_reg    [0:NST];
    logic [SIDE_W-1:0] s_reg    [0:NST];

    always_comb begin
        v_reg[0] = in_val;
        q_reg[0] = '0;
        r_reg[0] = '0;
        s_reg[0] = in_side;
    end

    for (genvar g = 0; g < NST; g++) begin : g_st
        logic [IN_W-1:0] q_next;
        logic [IN_W+1:0] r_next;
        always_comb begin
            logic [IN_W+1:0] r;
            logic [IN_W-1:0] q;
            logic [IN_W+1:0] t;
            r = r_reg[g];
            q = q_reg[g];
            for (int k = 0; k < 2; k++) begin
                if (2 * g + k < RW) begin
                    r = {r[IN_W-1:0], v_reg[g][IN_W-1-2*(2*g+k) -: 2]};
                    t = {q, 2'b01};
                    if (r >= t) begin
                        r = r - t;
                        q = {q[IN_W-2:0], 1'b1};
                    end else begin
                        q = {q[IN_W-2:0], 1'b0};
                    end
                end
            end
            q_next = q;
            r_next = r;
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                s_reg[g+1] <= '0;
            end else if (en) begin
                s_reg[g+1] <= s_reg[g];
            end
            if (en) begin
                v_reg[g+1] <= v_reg[g];
                q_reg[g+1] <= q_next;
                r_reg[g+1] <= r_next;
            end
        end
    end

    assign root = q_reg[NST][RW-1:0];
    assign rem = r_reg[NST][IN_W-1:0];
    assign out_side = s_reg[NST];
endmodule
`default_nettype wire

/* sv/aik_div.sv */
// aik_div: pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on nothing; carries a side payload alongside the quotient.
`timescale 1ns / 1ps
`default_nettype none
module aik_div #(
    parameter int NW = 42,
    parameter int DW = 26,
    parameter int SIDE_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic [NW-1:0]     num,
    input  wire logic [DW-1:0]     den,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic [NW-1:0]          quo,
    output logic [SIDE_W-1:0]      out_side
);
    logic [NW-1:0]     n_reg [0:NW];
    logic [DW:0]       r_reg [0:NW];
    logic [DW-1:0]     d_reg [0:NW];
    logic [SIDE_W-1:0] s_reg [0:NW];

    always_comb begin
        n_reg[0] = num;
        r_reg[0] = '0;
        d_reg[0] = den;
        s_reg[0] = in_side;
    end

    for (genvar g = 0; g < NW; g++) begin : g_st
        logic [DW+1:0] t;
        logic [DW:0]   r_next;
        logic [NW-1:0] n_next;
        always_comb begin
            t = {r_reg[g], n_reg[g][NW-1]};
            n_next = {n_reg[g][NW-2:0], 1'b0};
            if (t >= {2'b00, d_reg[g]}) begin
                r_next = (DW+1)'(t - {2'b00, d_reg[g]});
                n_next[0] = 1'b1;
            end else begin
                r_next = t[DW:0];
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                s_reg[g+1] <= '0;
            end else if (en) begin
                s_reg[g+1] <= s_reg[g];
            end
            if (en) begin
                n_reg[g+1] <= n_next;
                r_reg[g+1] <= r_next;
                d_reg[g+1] <= d_reg[g];
            end
        end
    end

    assign quo = n_reg[NW];
    assign out_side = s_reg[NW];
endmodule
`default_nettype wire

/* sv/aik_cordic.sv */
// aik_cordic: pipelined vectoring CORDIC, atan2(b, a) in 2^-20 degree, clamped to [0, 90].
// Depends on aik_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aik_cordic
    import aik_pkg::*;
#(
    parameter int STAGES = 16,
    parameter int IN_W = 27,
    parameter int SIDE_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic [IN_W-1:0]   a,
    input  wire logic [IN_W-1:0]   b,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic [ACC_W-1:0]       angle,
    output logic [SIDE_W-1:0]      out_side
);
    localparam int NS = (STAGES < TAB_LEN) ? STAGES : TAB_LEN;

    logic signed [CW-1:0]    x_reg [0:NS];
    logic signed [CW-1:0]    y_reg [0:NS];
    logic signed [ACC_W+1:0] a_reg [0:NS];
    logic [SIDE_W-1:0]       s_reg [0:NS];
    logic [ACC_W-1:0]        ang_reg;
    logic [SIDE_W-1:0]       so_reg;

    always_comb begin
        x_reg[0] = CW'({a, 16'd0});
        y_reg[0] = CW'({b, 16'd0});
        a_reg[0] = '0;
        s_reg[0] = in_side;
    end

    for (genvar g = 0; g < NS; g++) begin : g_st
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        assign xs = x_reg[g] >>> g;
        assign ys = y_reg[g] >>> g;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                s_reg[g+1] <= '0;
            end else if (en) begin
                s_reg[g+1] <= s_reg[g];
            end
            if (en) begin
                if (!y_reg[g][CW-1]) begin
                    x_reg[g+1] <= x_reg[g] + ys;
                    y_reg[g+1] <= y_reg[g] - xs;
                    a_reg[g+1] <= a_reg[g] + $signed({2'b00, atan_tab(5'(g))});
                end else begin
                    x_reg[g+1] <= x_reg[g] - ys;
                    y_reg[g+1] <= y_reg[g] + xs;
                    a_reg[g+1] <= a_reg[g] - $signed({2'b00, atan_tab(5'(g))});
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            so_reg <= '0;
        end else if (en) begin
            so_reg <= s_reg[NS];
        end
        if (en) begin
            if (a_reg[NS][ACC_W+1]) begin
                ang_reg <= '0;
            end else if (a_reg[NS] > $signed({2'b00, ANG_90})) begin
                ang_reg <= ANG_90;
            end else begin
                ang_reg <= a_reg[NS][ACC_W-1:0];
            end
        end
    end

    assign angle = ang_reg;
    assign out_side = so_reg;
endmodule
`default_nettype wire

/* sv/arm_inverse_kinematics.sv */
// arm_inverse_kinematics: top level, three-joint arm inverse kinematics pipeline.
// Depends on aik_pkg, aik_isqrt, aik_div, aik_cordic.
// The block takes one target point per clock, unless the output stalls, and returns
// one set of joint angles per point, in order. From the accepting edge to m_tvalid
// the path has two input/square stages, a 12-stage square root for the planar radius,
// a 47-stage divider for negative z, a 2-stage reach multiply, two parallel 12-stage
// square roots, three parallel CORDICs of CORDIC_STAGES + 1 stages for the half
// elbow, approach and base angles, and the output register. The whole datapath
// advances together and holds while the result register is full and not taken.
`timescale 1ns / 1ps
`default_nettype none
module arm_inverse_kinematics
    import aik_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [13:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // pos_x, pos_y, pos_z
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0] m_tdata  // base_angle, shoulder_angle, elbow_angle, status, pad
);
    typedef struct packed {
        logic               vld;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [13:0]        len;
    } pt_t;

    logic [13:0] link_reg;
    logic        en;
    logic        out_vld_reg;
    logic [55:0] out_dat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reg <= 14'd960;
        end else if (cfg_wr_en) begin
            link_reg <= cfg_wr_data;
        end
    end

    assign en = !out_vld_reg || m_tready;
    assign s_tready = en;

    // stage A: input register and squares
    pt_t         a_reg;
    logic [31:0] xx, zz2;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg.vld <= 1'b0;
        end else if (en) begin
            a_reg.vld <= s_tvalid;
        end
        if (en) begin
            a_reg.x <= s_tdata[15:0];
            a_reg.y <= s_tdata[31:16];
            a_reg.z <= s_tdata[47:32];
            a_reg.len <= link_reg;
        end
    end

    logic [31:0] xsq_reg, zsq_reg;
    pt_t         b_reg;
    assign xx  = 32'($signed(a_reg.x) * $signed(a_reg.x));
    assign zz2 = 32'($signed(a_reg.z) * $signed(a_reg.z));
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_reg.vld <= 1'b0;
        end else if (en) begin
            b_reg.vld <= a_reg.vld;
        end
        if (en) begin
            b_reg.x <= a_reg.x; b_reg.y <= a_reg.y; b_reg.z <= a_reg.z;
            b_reg.len <= a_reg.len;
            xsq_reg <= xx;
            zsq_reg <= zz2;
        end
    end

    // radius: sqrt((x^2+z^2) * 2^16), root carries 8 fraction bits
    localparam int PW = $bits(pt_t);
    logic [47:0]   r2;
    logic [23:0]   r_root;
    logic [PW+63:0] r_side_in, r_side_out;
    logic [47:0]   r_rem;
    assign r2 = {15'd0, 33'(xsq_reg) + 33'(zsq_reg)} << 16;
    assign r_side_in = {b_reg, xsq_reg, zsq_reg};
    aik_isqrt #(.IN_W(48), .SIDE_W(PW+64)) u_rsq (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_val(r2), .in_side(r_side_in),
        .root(r_root), .rem(r_rem), .out_side(r_side_out)
    );

    pt_t         c_pt;
    logic [31:0] c_xsq, c_zsq;
    logic        c_vld;
    logic [47:0] unused_rem;
    assign {c_pt, c_xsq, c_zsq} = r_side_out;
    assign unused_rem = r_rem;
    always_comb c_vld = c_pt.vld && aresetn;

    // zz for negative z: round((X^2-Z^2)/r); X^2 in 2^-16 mm^2, r in 2^-8 mm
    logic signed [33:0] c_num;
    logic [33:0]        c_anum;
    logic [46:0]        dnum;
    assign c_num  = $signed({2'b00, c_xsq}) - $signed({2'b00, c_zsq});
    assign c_anum = c_num[33] ? 34'(-c_num) : c_num;
    assign dnum   = 47'({c_anum, 16'd0}) + 47'(r_root[23:1]);

    localparam int DS = PW + 25 + 1;
    logic [DS-1:0] d_side_in, d_side_out;
    logic [46:0]   d_quo;
    pt_t           e_pt;
    logic [24:0]   e_r;
    logic          e_neg;
    assign d_side_in = {c_pt.vld & c_vld, c_pt.x, c_pt.y, c_pt.z, c_pt.len,
                        1'b0, r_root, c_num[33]};
    aik_div #(.NW(47), .DW(24), .SIDE_W(DS)) u_div (
        .aclk(aclk), .aresetn(aresetn), .en(en), .num(dnum),
        .den(r_root | 24'(r_root == 0)),
        .in_side(d_side_in), .quo(d_quo), .out_side(d_side_out)
    );
    assign {e_pt, e_r, e_neg} = d_side_out;

    // reach math; the base CORDIC runs later, in parallel with the other two CORDICs
    logic signed [47:0] e_zz;
    logic signed [47:0] e_d;
    logic [23:0]        e_ad, e_ay;
    always_comb begin
        if (!e_pt.z[15]) begin
            e_zz = 48'(e_r[23:0]);
        end else begin
            e_zz = e_neg ? -$signed(48'(d_quo)) : $signed(48'(d_quo));
        end
        e_d = e_zz - $signed({26'd0, e_pt.len, 8'd0});
    end
    assign e_ad = e_d[47] ? 24'(-e_d) : 24'(e_d);
    assign e_ay = {(e_pt.y[15] ? 16'(-e_pt.y) : e_pt.y), 8'd0};

    pt_t                f_pt;
    logic signed [31:0] f_d;
    logic [47:0]        f_dd, f_yy, f_lim;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_pt.vld <= 1'b0;
        end else if (en) begin
            f_pt.vld <= e_pt.vld;
        end
        if (en) begin
            f_pt.x <= e_pt.x; f_pt.y <= e_pt.y; f_pt.z <= e_pt.z; f_pt.len <= e_pt.len;
            f_d   <= 32'(e_d);
            f_dd  <= 48'(e_ad) * 48'(e_ad);
            f_yy  <= 48'(e_ay) * 48'(e_ay);
            f_lim <= 48'({e_pt.len, 9'd0}) * 48'({e_pt.len, 9'd0});
        end
    end

    logic [48:0] f_n2;
    logic [1:0]  f_st;
    assign f_n2 = 49'(f_dd) + 49'(f_yy);
    always_comb begin
        if (f_pt.x == 0 && f_pt.z == 0) f_st = ST_DEGEN;
        else if (f_n2 == 0) f_st = ST_DEGEN;
        else if (f_n2 > 49'(f_lim)) f_st = ST_REACH;
        else f_st = ST_OK;
    end

    pt_t                g_pt;
    logic signed [31:0] g_d;
    logic [47:0]        g_n2, g_w2;
    logic [1:0]         g_st;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_pt.vld <= 1'b0;
        end else if (en) begin
            g_pt.vld <= f_pt.vld;
        end
        if (en) begin
            g_pt.x <= f_pt.x; g_pt.y <= f_pt.y; g_pt.z <= f_pt.z; g_pt.len <= f_pt.len;
            g_d  <= f_d;
            g_st <= f_st;
            g_n2 <= 48'(f_n2);
            g_w2 <= (f_st == ST_OK) ? 48'(49'(f_lim) - f_n2) : 48'd0;
        end
    end

    localparam int QS = PW + 32 + 2;
    logic [QS-1:0] q_side_in, q_side_out;
    logic [23:0]   n_root, w_root;
    logic [47:0]   n_rem, w_rem;
    logic [QS-1:0] unused_w_side;
    assign q_side_in = {g_pt, g_d, g_st};
    aik_isqrt #(.IN_W(48), .SIDE_W(QS)) u_nsq (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_val(g_n2), .in_side(q_side_in),
        .root(n_root), .rem(n_rem), .out_side(q_side_out)
    );
    aik_isqrt #(.IN_W(48), .SIDE_W(QS)) u_wsq (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_val(g_w2), .in_side(q_side_in),
        .root(w_root), .rem(w_rem), .out_side(unused_w_side)
    );

    pt_t                h_pt;
    logic signed [31:0] h_d;
    logic [1:0]         h_st;
    assign {h_pt, h_d, h_st} = q_side_out;

    logic [31:0] h_ad;
    logic [23:0] h_ay, h_ax, h_az;
    assign h_ad = h_d[31] ? 32'(-h_d) : h_d;
    assign h_ay = {(h_pt.y[15] ? 16'(-h_pt.y) : h_pt.y), 8'd0};
    assign h_ax = {(h_pt.x[15] ? 16'(-h_pt.x) : h_pt.x), 8'd0};
    assign h_az = {(h_pt.z[15] ? 16'(-h_pt.z) : h_pt.z), 8'd0};

    localparam int KS = PW + 1 + 2;
    logic [KS-1:0] k_side_in, k_side_out;
    logic [ACC_W-1:0] half_ang, ac_ang, base_ang;
    logic [KS-1:0]    unused_k2, unused_k3;
    assign k_side_in = {h_pt, h_d[31], h_st};
    aik_cordic #(.STAGES(CORDIC_STAGES), .IN_W(32), .SIDE_W(KS)) u_half (
        .aclk(aclk), .aresetn(aresetn), .en(en), .a(32'(w_root)), .b(32'(n_root)),
        .in_side(k_side_in), .angle(half_ang), .out_side(k_side_out)
    );
    aik_cordic #(.STAGES(CORDIC_STAGES), .IN_W(32), .SIDE_W(KS)) u_ac (
        .aclk(aclk), .aresetn(aresetn), .en(en), .a(h_ad), .b(32'(h_ay)),
        .in_side(k_side_in), .angle(ac_ang), .out_side(unused_k2)
    );
    aik_cordic #(.STAGES(CORDIC_STAGES), .IN_W(32), .SIDE_W(KS)) u_base (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .a(32'(h_az)),
        .b(32'(h_ax)),
        .in_side(k_side_in), .angle(base_ang), .out_side(unused_k3)
    );

    pt_t  k_pt;
    logic k_dneg;
    logic [1:0] k_st;
    assign {k_pt, k_dneg, k_st} = k_side_out;

    logic signed [ACC_W+1:0] k_ac, k_bs, k_sh, k_el;
    logic signed [15:0]      o_base, o_sh, o_el;
    always_comb begin
        k_ac = k_dneg ? $signed({2'b00, ANG_180}) - $signed({2'b00, ac_ang})
                      : $signed({2'b00, ac_ang});
        k_bs = (k_pt.z == 0) ? $signed({2'b00, ANG_90}) : $signed({2'b00, base_ang});
        k_sh = $signed({2'b00, ANG_90}) - k_ac + $signed({2'b00, half_ang});
        k_el = $signed({1'b0, half_ang, 1'b0});
        o_base = 16'((k_bs + 32'sd4096) >>> 13);
        o_sh   = 16'((k_sh + 32'sd4096) >>> 13);
        o_el   = 16'((k_el + 32'sd4096) >>> 13);
        if ((k_pt.x[15] != k_pt.z[15] && k_pt.z != 0) || (k_pt.z == 0 && k_pt.x[15])) begin
            o_base = -o_base;
        end
        if (k_st != ST_OK) begin
            o_base = '0; o_sh = '0; o_el = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= k_pt.vld;
        end
        if (en) begin
            out_dat_reg <= {6'd0, k_st, o_el, o_sh, o_base};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_dat_reg;

    logic [47:0] unused_sink;
    assign unused_sink = n_rem ^ w_rem;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed under stall");
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[49:48] != ST_OK |-> m_tdata[47:0] == 48'd0)
        else $error("nonzero angles with bad status");
    a_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[49:48] != 2'd3)
        else $error("bad status code");
endmodule
`default_nettype wire

/* tb/arm_inverse_kinematics_tb.sv */
// arm_inverse_kinematics_tb: self-checking bench for the arm inverse kinematics pipeline.
// Predicts joint angles and status from the target point; depends on aik_pkg and the RTL.
`timescale 1ns / 1ps
module arm_inverse_kinematics_tb;
    import aik_pkg::*;

    localparam int STAGES = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;
    localparam longint ANG1 = 64'sd1 << 20;

    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } point_t;

    typedef struct packed {
        logic [5:0]         pad;
        logic [1:0]         status;
        logic signed [15:0] elbow;
        logic signed [15:0] shoulder;
        logic signed [15:0] base;
    } angles_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [13:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    arm_inverse_kinematics #(.CORDIC_STAGES(STAGES)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    logic [13:0] link_len = 14'd960;
    point_t      pending_points[$];
    angles_t     expected_angles[$];
    int          errors = 0;
    int          idle_cycles = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    bit          sending = 0;
    logic        s_fire = 1'b0;

    function automatic longint floor_shr(longint v, int s);
        return v >= 0 ? (v >>> s) : ~((~v) >>> s);
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint atan_deg(longint a, longint b);
        longint cx = a * 65536;
        longint cy = b * 65536;
        longint acc = 0;
        longint xs, ys;
        for (int i = 0; i < STAGES && i < TAB_LEN; i++) begin
            xs = floor_shr(cx, i);
            ys = floor_shr(cy, i);
            if (cy >= 0) begin
                cx = cx + ys; cy = cy - xs; acc += longint'(atan_tab(i[4:0]));
            end else begin
                cx = cx - ys; cy = cy + xs; acc -= longint'(atan_tab(i[4:0]));
            end
        end
        if (acc < 0) acc = 0;
        if (acc > 90 * ANG1) acc = 90 * ANG1;
        return acc;
    endfunction

    function automatic longint to_steps(longint a);
        return floor_shr(a + 4096, 13);
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic angles_t solve_joints(point_t p, logic [13:0] len);
        angles_t o;
        longint x = p.x, y = p.y, z = p.z;
        longint bx = x * 256, by = y * 256, bz = z * 256, lq = longint'(len) * 256;
        longint base = 0, sh = 0, el = 0, base_acc, r, zz, d, num, q, n, w, half, ac;
        longint unsigned n2, lim;
        logic [1:0] st = ST_OK;
        if (x == 0 && z == 0) begin
            st = ST_DEGEN;
        end else begin
            r = int_sqrt(bx * bx + bz * bz);
            base_acc = (z == 0) ? 90 * ANG1 : atan_deg(mag(bz), mag(bx));
            if (z >= 0) begin
                zz = r;
            end else begin
                num = bx * bx - bz * bz;
                q = (mag(num) + r / 2) / r;
                zz = num < 0 ? -q : q;
            end
            d = zz - lq;
            n2 = longint'(d * d) + longint'(by * by);
            lim = 4 * lq * lq;
            if (n2 == 0) begin
                st = ST_DEGEN;
            end else if (n2 > lim) begin
                st = ST_REACH;
            end else begin
                n = int_sqrt(n2);
                w = int_sqrt(lim - n2);
                half = atan_deg(w, n);
                ac = atan_deg(mag(d), mag(by));
                if (d < 0) ac = 180 * ANG1 - ac;
                base = to_steps(base_acc);
                if ((x < 0) != (z < 0) && z != 0) base = -base;
                if (z == 0 && x < 0) base = -base;
                el = to_steps(2 * half);
                sh = to_steps(90 * ANG1 - ac + half);
            end
        end
        o.pad = '0;
        o.status = st;
        o.base = base[15:0];
        o.shoulder = sh[15:0];
        o.elbow = el[15:0];
        return o;
    endfunction

    function automatic int pick_gap();
        int r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic check_result(angles_t e, angles_t a);
        if (a.base !== e.base) begin
            $display("%0t base: expected %0d actual %0d", $time, e.base, a.base);
            errors = errors + 1;
        end
        if (a.shoulder !== e.shoulder) begin
            $display("%0t shoulder: expected %0d actual %0d", $time, e.shoulder, a.shoulder);
            errors = errors + 1;
        end
        if (a.elbow !== e.elbow) begin
            $display("%0t elbow: expected %0d actual %0d", $time, e.elbow, a.elbow);
            errors = errors + 1;
        end
        if (a.status !== e.status) begin
            $display("%0t status: expected %0d actual %0d", $time, e.status, a.status);
            errors = errors + 1;
        end
    endtask

    // s_fire marks a transfer at the last rising edge
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_fire) begin
                if (send_gap == 0 && pending_points.size() > 0 && sending) begin
                    s_tdata <= pending_points.pop_front();
                    send_gap <= pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end else if (!s_tvalid && sending && pending_points.size() > 0) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end else begin
                    s_tdata <= pending_points.pop_front();
                    s_tvalid <= 1'b1;
                    send_gap <= pick_gap();
                end
            end
            if (recv_gap > 0) begin
                m_tready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else begin
                m_tready <= 1'b1;
                recv_gap <= pick_gap();
            end
        end
    end

    // track accepted points; predict with the register value current at acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_fire <= 1'b0;
        end else begin
            s_fire <= s_tvalid && s_tready;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (s_tvalid && s_tready) begin
                expected_angles.push_back(solve_joints(point_t'(s_tdata), link_len));
            end
            if (m_tvalid && m_tready) begin
                if (expected_angles.size() == 0) begin
                    $display("%0t unexpected transfer: actual %h", $time, m_tdata);
                    errors = errors + 1;
                end else begin
                    check_result(expected_angles.pop_front(), angles_t'(m_tdata));
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t watchdog timeout", $time);
                $display("arm_inverse_kinematics: mismatch");
                $finish;
            end
        end
    end

    function automatic point_t mk(int x, int y, int z);
        point_t p;
        p.x = x[15:0]; p.y = y[15:0]; p.z = z[15:0];
        return p;
    endfunction

    // mostly points within +-32 link lengths per axis, rest full range, some with x or z zero
    function automatic point_t rand_point(logic [13:0] len);
        point_t p;
        int span, sel;
        span = int'(len) * 32;
        if (span > 32767) span = 32767;
        sel = $urandom_range(0, 9);
        p = 48'({$urandom, $urandom});
        if (sel < 7) begin
            p.x = 16'($signed($urandom_range(0, 2 * span)) - span);
            p.y = 16'($signed($urandom_range(0, 2 * span)) - span);
            p.z = 16'($signed($urandom_range(0, 2 * span)) - span);
        end else if (sel == 7) begin
            p.z = '0;
        end else if (sel == 8) begin
            p.x = '0;
        end
        return p;
    endfunction

    task automatic drain();
        while (pending_points.size() > 0 || s_tvalid || expected_angles.size() > 0)
            @(posedge aclk);
        sending = 0;
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_link(logic [13:0] v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        link_len = v;
    endtask

    initial begin
        logic [13:0] lens[6];
        lens = '{14'd960, 14'd16, 14'd10922, 14'd0, 14'h3FFF, 14'd300};
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // directed: extremes, axis cases, degenerate and out of reach
        pending_points.push_back(mk(0, 0, 0));
        pending_points.push_back(mk(0, 1000, 0));
        pending_points.push_back(mk(100, 0, 0));
        pending_points.push_back(mk(-100, 0, 0));
        pending_points.push_back(mk(0, 0, 960));
        pending_points.push_back(mk(0, 500, 960));
        pending_points.push_back(mk(0, 0, 1920));
        pending_points.push_back(mk(0, 0, 1));
        pending_points.push_back(mk(500, 300, -400));
        pending_points.push_back(mk(-500, -300, -400));
        pending_points.push_back(mk(-500, 300, 400));
        pending_points.push_back(mk(32767, 32767, 32767));
        pending_points.push_back(mk(-32768, -32768, -32768));
        pending_points.push_back(mk(0, 1920, 0));
        pending_points.push_back(mk(900, -200, 50));
        pending_points.push_back(mk(-1, 1, -1));
        pending_points.push_back(mk(678, 0, 678));
        sending = 1;
        drain();
        foreach (lens[k]) begin
            set_link(lens[k]);
            for (int i = 0; i < 300; i++) pending_points.push_back(rand_point(lens[k]));
            pending_points.push_back(mk(0, 0, int'(lens[k])));
            sending = 1;
            drain();
        end
        if (errors == 0) begin
            $display("arm_inverse_kinematics: match");
        end else begin
            $display("arm_inverse_kinematics: mismatch");
        end
        $finish;
    end
endmodule
